// File: design/fcs_pkg.sv
package fcs_pkg;

  localparam int unsigned BUS_ADDR_W = 26;
  localparam int unsigned BUS_DATA_W = 32;
  localparam int unsigned SIZE_W     = 3;

  // command codes
  localparam logic [7:0] CMD_READ_ARRAY   = 8'hFF;
  localparam logic [7:0] CMD_READ_ARRAY_A = 8'hF0;
  localparam logic [7:0] CMD_CLEAR_STATUS = 8'h50;
  localparam logic [7:0] CMD_SUSPEND      = 8'hB0;
  localparam logic [7:0] CMD_CONFIRM      = 8'hD0;
  localparam logic [7:0] CMD_READ_STATUS  = 8'h70;
  localparam logic [7:0] CMD_READ_ID      = 8'h90;
  localparam logic [7:0] CMD_READ_CFI     = 8'h98;
  localparam logic [7:0] CMD_BLOCK_ERASE  = 8'h20;
  localparam logic [7:0] CMD_WORD_PROGRAM = 8'h41;
  localparam logic [7:0] CMD_BUF_PROGRAM  = 8'hE9;
  localparam logic [7:0] CMD_PROT_PROGRAM = 8'hC0;
  localparam logic [7:0] CMD_LOCK_SETUP   = 8'h60;
  localparam logic [7:0] CMD_BLANK_CHECK  = 8'hBC;
  localparam logic [7:0] CMD_READ_EFA     = 8'h94;
  localparam logic [7:0] CMD_EFA_PROGRAM  = 8'h44;
  localparam logic [7:0] CMD_EFA_ERASE    = 8'h24;
  localparam logic [7:0] CMD_EFA_LOCK     = 8'h64;

  localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_SECOND  = 4'b0010,
    PH_DATA    = 4'b0100,
    PH_CONFIRM = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_STAY = 2'd0,
    SEQ_END  = 2'd1,
    SEQ_ERR  = 2'd2
  } seq_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] active_cmd;
    logic       array_flag;
    logic       irq_held;
    logic       irq_missed;
  } state_t;

  typedef struct packed {
    logic                  req_type;
    logic [BUS_ADDR_W-1:0] bus_addr;
    logic [BUS_DATA_W-1:0] bus_data;
    logic [SIZE_W-1:0]     bus_size;
    logic                  irq_deferred;
  } item_t;

  typedef struct packed {
    logic                  array_mode;
    logic                  mem_we;
    logic [BUS_ADDR_W-1:0] mem_addr;
    logic [BUS_DATA_W-1:0] mem_data;
    logic [SIZE_W-1:0]     mem_bytes;
    logic                  restore_irq;
    logic                  hold_irq;
    logic                  send_read_array;
    logic                  cmd_error;
  } result_t;

endpackage

// File: design/fcs_step.sv
module fcs_step #(
  parameter int unsigned ADDR_BITS  = 26,
  parameter int unsigned COUNT_BITS = 16
) (
  input  fcs_pkg::item_t         item_i,
  input  fcs_pkg::state_t        state_i,
  input  logic [COUNT_BITS:0]    words_left_i,
  output fcs_pkg::state_t        state_o,
  output logic [COUNT_BITS:0]    words_left_o,
  output fcs_pkg::result_t       result_o
);

  localparam int unsigned AW       = fcs_pkg::BUS_ADDR_W;
  localparam int unsigned KeepBits = (ADDR_BITS < AW) ? ADDR_BITS : AW;
  localparam logic [AW-1:0] AddrMask = AW'((64'd1 << KeepBits) - 64'd1);

  logic           missed;
  logic [7:0]     code;
  logic           store;
  fcs_pkg::seq_e  seq;
  logic [COUNT_BITS:0] take;

  assign code = item_i.bus_data[7:0];
  assign missed = state_i.irq_missed | (item_i.irq_deferred & state_i.irq_held);
  assign take = (item_i.bus_size == fcs_pkg::SIZE_WORD) ? (COUNT_BITS+1)'(2)
                                                         : (COUNT_BITS+1)'(1);

  always_comb begin
    state_o            = state_i;
    state_o.irq_missed = missed;
    words_left_o       = words_left_i;
    seq                = fcs_pkg::SEQ_STAY;
    store              = 1'b0;

    if (item_i.req_type) begin
      // status read ends read-status
      if (state_i.phase == fcs_pkg::PH_SECOND &&
          state_i.active_cmd == fcs_pkg::CMD_READ_STATUS) begin
        seq = fcs_pkg::SEQ_ERR;
      end
    end else begin
      case (state_i.phase)
        fcs_pkg::PH_IDLE: begin
          state_o.array_flag = 1'b0;
          case (code)
            fcs_pkg::CMD_READ_ARRAY_A, fcs_pkg::CMD_READ_ARRAY,
            fcs_pkg::CMD_CLEAR_STATUS, fcs_pkg::CMD_SUSPEND,
            fcs_pkg::CMD_CONFIRM: begin
              seq = fcs_pkg::SEQ_END;
            end
            fcs_pkg::CMD_READ_STATUS, fcs_pkg::CMD_READ_ID, fcs_pkg::CMD_READ_CFI,
            fcs_pkg::CMD_BLOCK_ERASE, fcs_pkg::CMD_WORD_PROGRAM,
            fcs_pkg::CMD_BUF_PROGRAM, fcs_pkg::CMD_PROT_PROGRAM,
            fcs_pkg::CMD_LOCK_SETUP, fcs_pkg::CMD_BLANK_CHECK,
            fcs_pkg::CMD_READ_EFA, fcs_pkg::CMD_EFA_PROGRAM,
            fcs_pkg::CMD_EFA_ERASE, fcs_pkg::CMD_EFA_LOCK: begin
              state_o.phase      = fcs_pkg::PH_SECOND;
              state_o.active_cmd = code;
              state_o.irq_held   = 1'b1;
              state_o.irq_missed = 1'b0;
            end
            default: begin
              seq = fcs_pkg::SEQ_ERR;
            end
          endcase
        end
        fcs_pkg::PH_SECOND: begin
          case (state_i.active_cmd)
            fcs_pkg::CMD_READ_CFI, fcs_pkg::CMD_READ_STATUS, fcs_pkg::CMD_READ_ID,
            fcs_pkg::CMD_LOCK_SETUP, fcs_pkg::CMD_EFA_LOCK,
            fcs_pkg::CMD_EFA_PROGRAM: begin
              seq = fcs_pkg::SEQ_END;
            end
            fcs_pkg::CMD_BLOCK_ERASE, fcs_pkg::CMD_BLANK_CHECK,
            fcs_pkg::CMD_EFA_ERASE: begin
              seq = (code == fcs_pkg::CMD_CONFIRM || code == fcs_pkg::CMD_READ_ARRAY)
                    ? fcs_pkg::SEQ_END : fcs_pkg::SEQ_ERR;
            end
            fcs_pkg::CMD_WORD_PROGRAM: begin
              if (item_i.bus_size == fcs_pkg::SIZE_HALF) begin
                store = 1'b1;
                seq   = fcs_pkg::SEQ_END;
              end else begin
                seq = fcs_pkg::SEQ_ERR;
              end
            end
            fcs_pkg::CMD_BUF_PROGRAM: begin
              words_left_o  = {1'b0, item_i.bus_data[COUNT_BITS-1:0]}
                              + (COUNT_BITS+1)'(1);
              state_o.phase = fcs_pkg::PH_DATA;
            end
            default: begin
              seq = fcs_pkg::SEQ_ERR;
            end
          endcase
        end
        fcs_pkg::PH_DATA: begin
          if (state_i.active_cmd != fcs_pkg::CMD_BUF_PROGRAM ||
              (item_i.bus_size != fcs_pkg::SIZE_HALF &&
               item_i.bus_size != fcs_pkg::SIZE_WORD)) begin
            seq = fcs_pkg::SEQ_ERR;
          end else begin
            store = 1'b1;
            // done at zero or below, so an oversized last word saturates
            if (words_left_i <= take) begin
              words_left_o  = '0;
              state_o.phase = fcs_pkg::PH_CONFIRM;
            end else begin
              words_left_o = words_left_i - take;
            end
          end
        end
        fcs_pkg::PH_CONFIRM: begin
          seq = (state_i.active_cmd == fcs_pkg::CMD_BUF_PROGRAM &&
                 code == fcs_pkg::CMD_CONFIRM) ? fcs_pkg::SEQ_END : fcs_pkg::SEQ_ERR;
        end
        default: begin
          seq = fcs_pkg::SEQ_ERR;
        end
      endcase
    end

    result_o = '0;
    if (store) begin
      result_o.mem_we    = 1'b1;
      result_o.mem_addr  = item_i.bus_addr & AddrMask;
      result_o.mem_data  = (item_i.bus_size == fcs_pkg::SIZE_HALF)
                           ? {16'h0000, item_i.bus_data[15:0]} : item_i.bus_data;
      result_o.mem_bytes = item_i.bus_size;
    end

    if (seq != fcs_pkg::SEQ_STAY) begin
      state_o.phase        = fcs_pkg::PH_IDLE;
      state_o.active_cmd   = 8'h00;
      state_o.array_flag   = 1'b1;
      state_o.irq_held     = 1'b0;
      state_o.irq_missed   = 1'b0;
      words_left_o         = '0;
      result_o.restore_irq = missed;
    end
    // the status read exit goes idle without either pulse
    result_o.send_read_array = (seq == fcs_pkg::SEQ_END);
    result_o.cmd_error       = (seq == fcs_pkg::SEQ_ERR) & ~item_i.req_type;
    result_o.array_mode      = state_o.array_flag;
    result_o.hold_irq        = state_o.irq_held;
  end

endmodule

// File: design/flash_command_sequencer.sv
// channel   direction  handshake                 payload
// in        to block   in_valid_i / in_stall_o   req_type, bus_addr, bus_data, bus_size,
//                                                irq_deferred
// out       from block out_valid_o / out_stall_i array_mode, mem_we, mem_addr, mem_data,
//                                                mem_bytes, restore_irq, hold_irq,
//                                                send_read_array, cmd_error
// one result per transfer in; it passes through the input register, then the result register
// one transfer per cycle sustained while out is not stalled; decode and state update are combinational
// reset puts the sequencer idle in array mode with interrupts released
// a stall on out holds the result register and, once the input register is full, stalls in
module flash_command_sequencer #(
  parameter int unsigned ADDR_BITS  = 26,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [25:0] bus_addr_i,
  input  logic [31:0] bus_data_i,
  input  logic [2:0]  bus_size_i,
  input  logic        irq_deferred_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        array_mode_o,
  output logic        mem_we_o,
  output logic [25:0] mem_addr_o,
  output logic [31:0] mem_data_o,
  output logic [2:0]  mem_bytes_o,
  output logic        restore_irq_o,
  output logic        hold_irq_o,
  output logic        send_read_array_o,
  output logic        cmd_error_o
);

  logic                in_valid_q;
  fcs_pkg::item_t      item_q;
  fcs_pkg::state_t     state_q, state_d;
  logic [COUNT_BITS:0] words_left_q, words_left_d;
  fcs_pkg::result_t    result_q, result_d;
  logic                out_valid_q;
  logic                advance;
  logic                fire;
  logic                in_xfer;

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign fire       = in_valid_q & advance;
  assign in_stall_o = in_valid_q & ~advance;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  fcs_step #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .item_i       (item_q),
    .state_i      (state_q),
    .words_left_i (words_left_q),
    .state_o      (state_d),
    .words_left_o (words_left_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      state_q.phase      <= fcs_pkg::PH_IDLE;
      state_q.active_cmd <= 8'h00;
      state_q.array_flag <= 1'b1;
      state_q.irq_held   <= 1'b0;
      state_q.irq_missed <= 1'b0;
      words_left_q       <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        state_q      <= state_d;
        words_left_q <= words_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.req_type     <= req_type_i;
      item_q.bus_addr     <= bus_addr_i;
      item_q.bus_data     <= bus_data_i;
      item_q.bus_size     <= bus_size_i;
      item_q.irq_deferred <= irq_deferred_i;
    end
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign array_mode_o      = result_q.array_mode;
  assign mem_we_o          = result_q.mem_we;
  assign mem_addr_o        = result_q.mem_addr;
  assign mem_data_o        = result_q.mem_data;
  assign mem_bytes_o       = result_q.mem_bytes;
  assign restore_irq_o     = result_q.restore_irq;
  assign hold_irq_o        = result_q.hold_irq;
  assign send_read_array_o = result_q.send_read_array;
  assign cmd_error_o       = result_q.cmd_error;

`ifndef NO_ASSERTIONS
  a_held_not_array: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hold_irq_o && array_mode_o))
    else $error("interrupts held while in array mode");

  a_no_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mem_we_o) |-> (mem_bytes_o == 3'd0 && mem_data_o == 32'd0))
    else $error("store fields set without a store");

  a_end_or_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(send_read_array_o && cmd_error_o))
    else $error("sequence both ended and failed");

  a_restore_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && restore_irq_o) |-> (!hold_irq_o && array_mode_o))
    else $error("interrupt restored without returning idle");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// File: sim/testbench.sv
module testbench;
  import fcs_pkg::*;

  localparam int unsigned ADDR_W     = 26;
  localparam int unsigned COUNT_W    = 16;
  localparam int          DIR_ROWS   = 25;
  localparam int          ITEMS      = 1100;
  localparam int          IDLE_PCT   = 23;
  localparam int          CALM_FROM  = 500;
  localparam int          CALM_TO    = 750;
  localparam int          PAUSE_AT   = 400;
  localparam int          TAIL_WAIT  = 8;
  localparam int          WDOG_LIMIT = 2000;
  localparam int          MAX_BEATS  = 60;

  localparam result_t RES_IDLE_READ   = '{array_mode: 1'b1, default: '0};
  localparam result_t RES_READ_ARRAY  = '{array_mode: 1'b1, send_read_array: 1'b1,
                                          default: '0};
  localparam result_t RES_BAD_CMD     = '{array_mode: 1'b1, cmd_error: 1'b1, default: '0};
  localparam result_t RES_STATUS_EXIT = '{array_mode: 1'b1, restore_irq: 1'b1, default: '0};
  localparam result_t RES_WORD_STORE  = '{array_mode: 1'b1, mem_we: 1'b1,
                                          mem_addr: 26'h3FFFFFF, mem_data: 32'h0000FFFF,
                                          mem_bytes: SIZE_HALF, send_read_array: 1'b1,
                                          default: '0};

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        req_type_i     = 1'b0;
  logic [25:0] bus_addr_i     = '0;
  logic [31:0] bus_data_i     = '0;
  logic [2:0]  bus_size_i     = SIZE_WORD;
  logic        irq_deferred_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        array_mode_o;
  logic        mem_we_o;
  logic [25:0] mem_addr_o;
  logic [31:0] mem_data_o;
  logic [2:0]  mem_bytes_o;
  logic        restore_irq_o;
  logic        hold_irq_o;
  logic        send_read_array_o;
  logic        cmd_error_o;

  // predicted sequencer state
  phase_e           flash_phase  = PH_IDLE;
  logic [7:0]       latched_cmd  = '0;
  logic [COUNT_W:0] units_left   = '0;
  logic             array_on     = 1'b1;
  logic             irq_held_q   = 1'b0;
  logic             irq_missed_q = 1'b0;

  result_t  pending_results [$];
  dir_row_t dir_tab [DIR_ROWS];
  bit       calm        = 1'b0;
  int       sent        = 0;
  int       fails       = 0;
  int       idle_cycles = 0;
  int       n_checked   = 0;
  int       n_stores    = 0;
  int       n_errors    = 0;
  int       n_restores  = 0;

  flash_command_sequencer #(
    .ADDR_BITS (ADDR_W),
    .COUNT_BITS(COUNT_W)
  ) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t next_flash_result(item_t it);
    result_t          r;
    logic [7:0]       code;
    seq_e             verdict;
    bit               drop_seq;
    logic [COUNT_W:0] take;
    r        = '0;
    code     = it.bus_data[7:0];
    verdict  = SEQ_STAY;
    drop_seq = 1'b0;
    if (it.irq_deferred && irq_held_q) irq_missed_q = 1'b1;
    if (it.req_type) begin
      drop_seq = (flash_phase == PH_SECOND) && (latched_cmd == CMD_READ_STATUS);
    end else begin
      case (flash_phase)
        PH_IDLE: begin
          array_on = 1'b0;
          case (code)
            CMD_READ_ARRAY_A, CMD_READ_ARRAY, CMD_CLEAR_STATUS, CMD_SUSPEND, CMD_CONFIRM:
              verdict = SEQ_END;
            CMD_READ_STATUS, CMD_READ_ID, CMD_READ_CFI, CMD_BLOCK_ERASE, CMD_WORD_PROGRAM,
            CMD_BUF_PROGRAM, CMD_PROT_PROGRAM, CMD_LOCK_SETUP, CMD_BLANK_CHECK,
            CMD_READ_EFA, CMD_EFA_PROGRAM, CMD_EFA_ERASE, CMD_EFA_LOCK: begin
              flash_phase  = PH_SECOND;
              latched_cmd  = code;
              irq_held_q   = 1'b1;
              irq_missed_q = 1'b0;
            end
            default: verdict = SEQ_ERR;
          endcase
        end
        PH_SECOND: begin
          case (latched_cmd)
            CMD_READ_CFI, CMD_READ_STATUS, CMD_READ_ID, CMD_LOCK_SETUP, CMD_EFA_LOCK,
            CMD_EFA_PROGRAM:
              verdict = SEQ_END;
            CMD_BLOCK_ERASE, CMD_BLANK_CHECK, CMD_EFA_ERASE: begin
              if (code == CMD_CONFIRM || code == CMD_READ_ARRAY) verdict = SEQ_END;
              else verdict = SEQ_ERR;
            end
            CMD_WORD_PROGRAM: begin
              if (it.bus_size != SIZE_HALF) begin
                verdict = SEQ_ERR;
              end else begin
                r.mem_we    = 1'b1;
                r.mem_addr  = it.bus_addr;
                r.mem_data  = {16'h0, it.bus_data[15:0]};
                r.mem_bytes = SIZE_HALF;
                verdict     = SEQ_END;
              end
            end
            CMD_BUF_PROGRAM: begin
              units_left  = {1'b0, it.bus_data[COUNT_W-1:0]} + 1'b1;
              flash_phase = PH_DATA;
            end
            default: verdict = SEQ_ERR;
          endcase
        end
        PH_DATA: begin
          if (latched_cmd != CMD_BUF_PROGRAM ||
              (it.bus_size != SIZE_HALF && it.bus_size != SIZE_WORD)) begin
            verdict = SEQ_ERR;
          end else begin
            take = (it.bus_size == SIZE_WORD) ? 2 : 1;
            // an oversized last word saturates the count instead of wrapping
            if (units_left <= take) begin
              units_left  = '0;
              flash_phase = PH_CONFIRM;
            end else begin
              units_left = units_left - take;
            end
            r.mem_we    = 1'b1;
            r.mem_addr  = it.bus_addr;
            r.mem_data  = (it.bus_size == SIZE_HALF) ? {16'h0, it.bus_data[15:0]} :
                                                        it.bus_data;
            r.mem_bytes = it.bus_size;
          end
        end
        default: begin
          if (latched_cmd == CMD_BUF_PROGRAM && code == CMD_CONFIRM) verdict = SEQ_END;
          else verdict = SEQ_ERR;
        end
      endcase
    end
    if (drop_seq || verdict != SEQ_STAY) begin
      r.restore_irq = irq_missed_q;
      flash_phase   = PH_IDLE;
      latched_cmd   = '0;
      units_left    = '0;
      array_on      = 1'b1;
      irq_held_q    = 1'b0;
      irq_missed_q  = 1'b0;
    end
    r.send_read_array = (verdict == SEQ_END);
    r.cmd_error       = (verdict == SEQ_ERR);
    r.array_mode      = array_on;
    r.hold_irq        = irq_held_q;
    return r;
  endfunction

  function automatic logic [7:0] code_at(int k);
    case (k)
      0:       return CMD_READ_ARRAY;
      1:       return CMD_READ_ARRAY_A;
      2:       return CMD_CLEAR_STATUS;
      3:       return CMD_SUSPEND;
      4:       return CMD_CONFIRM;
      5:       return CMD_READ_ID;
      6:       return CMD_READ_CFI;
      7:       return CMD_LOCK_SETUP;
      8:       return CMD_EFA_LOCK;
      9:       return CMD_EFA_PROGRAM;
      10:      return CMD_BLOCK_ERASE;
      11:      return CMD_BLANK_CHECK;
      12:      return CMD_EFA_ERASE;
      13:      return CMD_PROT_PROGRAM;
      14:      return CMD_READ_EFA;
      15:      return CMD_READ_STATUS;
      16:      return CMD_WORD_PROGRAM;
      17:      return CMD_BUF_PROGRAM;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic item_t cmd_write(logic [7:0] code);
    item_t it;
    it.req_type      = 1'b0;
    it.bus_addr      = 26'($urandom());
    it.bus_data      = $urandom();
    it.bus_data[7:0] = code;
    it.bus_size      = 3'($urandom_range(1, 4));
    it.irq_deferred  = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  function automatic item_t read_access();
    item_t it;
    it          = cmd_write(8'($urandom()));
    it.req_type = 1'b1;
    return it;
  endfunction

  task automatic send_transfer(input item_t it, input bit typed = 1'b0,
                               input result_t want = '0);
    result_t guess;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= it.req_type;
    bus_addr_i     <= it.bus_addr;
    bus_data_i     <= it.bus_data;
    bus_size_i     <= it.bus_size;
    irq_deferred_i <= it.irq_deferred;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    guess = next_flash_result(it);
    pending_results.push_back(typed ? want : guess);
    sent++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic maybe_reads();
    while ($urandom_range(0, 5) == 0) send_transfer(read_access());
  endtask

  task automatic random_sequence();
    item_t it;
    int    kind;
    int    cnt;
    int    units;
    int    beats;
    bit    aborted;
    kind = $urandom_range(0, 11);
    case (kind)
      0: send_transfer(cmd_write(code_at($urandom_range(0, 4))));
      1: begin
        send_transfer(cmd_write(CMD_READ_STATUS));
        if ($urandom_range(0, 3) != 0) send_transfer(read_access());
        else send_transfer(cmd_write(8'($urandom())));
      end
      2: begin
        send_transfer(cmd_write(code_at($urandom_range(5, 9))));
        maybe_reads();
        send_transfer(cmd_write(8'($urandom())));
      end
      3: begin
        send_transfer(cmd_write(code_at($urandom_range(10, 12))));
        maybe_reads();
        cnt = $urandom_range(0, 9);
        send_transfer(cmd_write(cnt < 5 ? CMD_CONFIRM :
                                cnt < 9 ? CMD_READ_ARRAY : 8'($urandom())));
      end
      4: begin
        send_transfer(cmd_write(CMD_WORD_PROGRAM));
        maybe_reads();
        it = cmd_write(8'($urandom()));
        if ($urandom_range(0, 7) != 0) it.bus_size = SIZE_HALF;
        send_transfer(it);
      end
      5, 6, 7: begin
        send_transfer(cmd_write(CMD_BUF_PROGRAM));
        maybe_reads();
        // mostly short buffers, now and then a long one that gets aborted
        if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, 65535);
        else if ($urandom_range(0, 4) == 0) cnt = $urandom_range(8, 40);
        else cnt = $urandom_range(0, 7);
        it = cmd_write(8'($urandom()));
        it.bus_data[15:0] = 16'(cnt);
        send_transfer(it);
        units   = cnt + 1;
        beats   = 0;
        aborted = 1'b0;
        while (units > 0) begin
          maybe_reads();
          it = cmd_write(8'($urandom()));
          if (beats == MAX_BEATS || $urandom_range(0, 49) == 0) begin
            it.bus_size = $urandom_range(0, 1) ? 3'd1 : 3'd3;
            aborted     = 1'b1;
            units       = 0;
          end else begin
            it.bus_size = $urandom_range(0, 1) ? SIZE_HALF : SIZE_WORD;
            units       = units - ((it.bus_size == SIZE_WORD) ? 2 : 1);
            if (units < 0) units = 0;
            beats++;
          end
          send_transfer(it);
        end
        if (!aborted) begin
          maybe_reads();
          send_transfer(cmd_write($urandom_range(0, 6) == 0 ? 8'($urandom()) : CMD_CONFIRM));
        end
      end
      8: begin
        send_transfer(cmd_write(code_at($urandom_range(13, 14))));
        send_transfer(cmd_write(8'($urandom())));
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) send_transfer(read_access());
          else send_transfer(cmd_write(code_at($urandom_range(0, 19))));
        end
      end
    endcase
  endtask

  function automatic void field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fails++;
    end
  endfunction

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result transfer %h", $time, got);
      fails++;
      return;
    end
    want = pending_results.pop_front();
    field_diff("array_mode", want.array_mode, got.array_mode);
    field_diff("mem_we", want.mem_we, got.mem_we);
    field_diff("mem_addr", want.mem_addr, got.mem_addr);
    field_diff("mem_data", want.mem_data, got.mem_data);
    field_diff("mem_bytes", want.mem_bytes, got.mem_bytes);
    field_diff("restore_irq", want.restore_irq, got.restore_irq);
    field_diff("hold_irq", want.hold_irq, got.hold_irq);
    field_diff("send_read_array", want.send_read_array, got.send_read_array);
    field_diff("cmd_error", want.cmd_error, got.cmd_error);
    n_checked++;
    n_stores   += want.mem_we;
    n_errors   += want.cmd_error;
    n_restores += want.restore_irq;
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t got;
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {array_mode_o, mem_we_o, mem_addr_o, mem_data_o, mem_bytes_o,
               restore_irq_o, hold_irq_o, send_read_array_o, cmd_error_o};
        check_result(got);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    dir_tab = '{
      '{'{1'b1, 26'h0000000, 32'h00000000, 3'd4, 1'b0}, 1'b1, RES_IDLE_READ},
      '{'{1'b0, 26'h3FFFFFF, 32'hFFFFFFFF, 3'd4, 1'b1}, 1'b1, RES_READ_ARRAY},
      '{'{1'b0, 26'h0000000, 32'h00000000, 3'd1, 1'b0}, 1'b1, RES_BAD_CMD},
      '{'{1'b0, 26'h0000000, 32'h00000041, 3'd1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h3FFFFFF, 32'hFFFFFFFF, 3'd2, 1'b0}, 1'b1, RES_WORD_STORE},
      '{'{1'b0, 26'h1555555, 32'hAAAAAA70, 3'd3, 1'b1}, 1'b0, '0},
      // deferred interrupt while read-status is held, then the read ends it
      '{'{1'b1, 26'h2AAAAAA, 32'h55555555, 3'd1, 1'b1}, 1'b1, RES_STATUS_EXIT},
      '{'{1'b0, 26'h0000100, 32'h000000E9, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000104, 32'hFFFF0000, 3'd4, 1'b1}, 1'b0, '0},
      '{'{1'b0, 26'h0000200, 32'h12345678, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000000, 32'h000000D0, 3'd2, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000300, 32'h000000E9, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000304, 32'h0000FFFF, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000202, 32'hDEADBEEF, 3'd2, 1'b1}, 1'b0, '0},
      '{'{1'b0, 26'h0000204, 32'h00000000, 3'd1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000000, 32'h000000C0, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000010, 32'h0000ABCD, 3'd2, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000000, 32'h00000094, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000020, 32'h00000000, 3'd2, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000000, 32'h00000044, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000030, 32'h87654321, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000000, 32'h00000020, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000040, 32'h00000000, 3'd4, 1'b1}, 1'b0, '0},
      '{'{1'b0, 26'h0000000, 32'h00000041, 3'd4, 1'b0}, 1'b0, '0},
      '{'{1'b0, 26'h0000050, 32'h00001234, 3'd4, 1'b0}, 1'b0, '0}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) send_transfer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
    wait_for_drain();
    while (sent < ITEMS) begin
      calm = (sent >= CALM_FROM && sent < CALM_TO);
      if (sent >= PAUSE_AT && sent < PAUSE_AT + MAX_BEATS && $urandom_range(0, 3) == 0)
        wait_for_drain();
      random_sequence();
    end
    calm = 1'b0;
    wait_for_drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("covered %0d bus accesses: %0d directed, the rest random command sequences",
             sent, DIR_ROWS);
    $display("%0d results checked: %0d array stores, %0d command errors, %0d irq restores",
             n_checked, n_stores, n_errors, n_restores);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: flash_command_sequencer.f
design/fcs_pkg.sv
design/fcs_step.sv
design/flash_command_sequencer.sv
sim/testbench.sv
